/* src/cfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants for the checksummed frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

   localparam int BYTE_W      = 8;
   localparam int ID_LIMIT_W  = 9;
   localparam int KIND_W      = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;
   localparam int RSP_DATA_W  = 4 * BYTE_W;

   // Register reset values
   localparam logic [BYTE_W-1:0]     HEADER_BYTE_RESET = 8'd90;
   localparam logic [ID_LIMIT_W-1:0] ID_LIMIT_RESET    = 9'd8;

   // Register indexes on the control port
   localparam logic [CSR_INDEX_W-1:0] CSR_HEADER_BYTE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ID_LIMIT    = 2'd1;

   // Event kinds reported with each result
   localparam logic [KIND_W-1:0] EV_NONE = 2'd0;
   localparam logic [KIND_W-1:0] EV_DATA = 2'd1;
   localparam logic [KIND_W-1:0] EV_GOOD = 2'd2;
   localparam logic [KIND_W-1:0] EV_BAD  = 2'd3;

   // Parser phases, one-hot
   typedef enum logic [4:0] {
      PH_HUNT  = 5'b00001,
      PH_ID    = 5'b00010,
      PH_LEN   = 5'b00100,
      PH_DATA  = 5'b01000,
      PH_CHECK = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0]     header_byte;
      logic [ID_LIMIT_W-1:0] id_limit;
   } cfg_type;

   typedef struct packed {
      logic [KIND_W-1:0] event_kind;
      logic [BYTE_W-1:0] payload_byte;
      logic [BYTE_W-1:0] payload_index;
      logic [BYTE_W-1:0] frame_id;
      logic [BYTE_W-1:0] frame_length;
   } result_type;

endpackage
`default_nettype wire

/* src/checksummed_frame_receiver.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// checksummed_frame_receiver
// Deframes header / id / length / payload / sum8 packets from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one received byte per beat. rsp_* returns exactly one
//   result beat per request beat, in order: the event kind in tuser and the
//   payload byte, payload index, frame id and frame length in tdata.
//   csr_* writes the header byte (index 0) and the id limit (index 1); write
//   only while no request beat is in flight. csr_ready is always high.
//   The framing state is updated by combinational logic between the input
//   register and the result register; a new byte is accepted every cycle
//   unless a low rsp_tready has filled both registers.
//   Reset clears both stages, puts the parser in header hunt with cleared
//   sum, id, length and count, and loads the register defaults (header 90,
//   id limit 8).
//   When rsp_tready is low the result register holds its beat, the input
//   register fills behind it, and then req_tready drops until rsp_tready
//   returns; no beat is lost or repeated.
// ----------------------------------------------------------------------------
module checksummed_frame_receiver
   import cfr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request: tdata = rx_byte[7:0]
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [BYTE_W-1:0]      req_tdata,
   // response: tdata = payload_byte[7:0], payload_index[15:8],
   //           frame_id[23:16], frame_length[31:24]
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   // response: tuser = event_kind[1:0]
   output logic [KIND_W-1:0]           rsp_tuser,
   // control register writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type    cfg;
   logic       res_valid;
   logic       res_ready;
   result_type res;
   result_type out_res;

   assign csr_ready = 1'b1;

   cfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   cfr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   cfr_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_res   (out_res)
   );

   // Pack the result beat
   assign rsp_tuser = out_res.event_kind;
   assign rsp_tdata = {out_res.frame_length, out_res.frame_id,
                       out_res.payload_index, out_res.payload_byte};

endmodule
`default_nettype wire

/* src/cfr_csr.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_csr
// Control registers: header byte and id limit, written over the csr port.
// ----------------------------------------------------------------------------
module cfr_csr
   import cfr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write beat; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_HEADER_BYTE: cfg_in.header_byte = csr_data[BYTE_W-1:0];
            CSR_ID_LIMIT:    cfg_in.id_limit    = csr_data[ID_LIMIT_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_byte <= HEADER_BYTE_RESET;
         cfg_ff.id_limit    <= ID_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* src/cfr_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_parser
// Input register and per-byte framing state machine with running checksum.
// ----------------------------------------------------------------------------
module cfr_parser
   import cfr_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire cfg_type           cfg,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [BYTE_W-1:0] in_byte,
   output logic                   res_valid,
   input  wire logic              res_ready,
   output result_type             res
);

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [BYTE_W-1:0] id_ff, id_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic [BYTE_W-1:0] count_ff, count_in;
   logic [BYTE_W-1:0] count_inc;
   logic [BYTE_W-1:0] sum_add;
   logic              advance;

   // A held beat moves on when the output stage can take it
   assign advance   = valid_ff && res_ready;
   assign in_ready  = !valid_ff || res_ready;
   assign res_valid = valid_ff;

   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign byte_in   = (in_valid && in_ready) ? in_byte : byte_ff;
   assign count_inc = count_ff + 1'b1;
   assign sum_add   = sum_ff + byte_ff;

   // Work out the next framing state and the result for the held byte
   always_comb begin
      phase_in = phase_ff;
      sum_in   = sum_ff;
      id_in    = id_ff;
      len_in   = len_ff;
      count_in = count_ff;
      res.event_kind    = EV_NONE;
      res.payload_byte  = '0;
      res.payload_index = '0;
      case (phase_ff)
         PH_HUNT: begin
            if (byte_ff == cfg.header_byte) begin
               sum_in   = byte_ff;
               id_in    = '0;
               len_in   = '0;
               count_in = '0;
               phase_in = PH_ID;
            end
         end
         PH_ID: begin
            if ({1'b0, byte_ff} < cfg.id_limit) begin
               id_in    = byte_ff;
               sum_in   = sum_add;
               phase_in = PH_LEN;
            end else begin
               phase_in = PH_HUNT;
            end
         end
         PH_LEN: begin
            len_in   = byte_ff;
            sum_in   = sum_add;
            phase_in = (byte_ff == '0) ? PH_CHECK : PH_DATA;
         end
         PH_DATA: begin
            res.event_kind    = EV_DATA;
            res.payload_byte  = byte_ff;
            res.payload_index = count_ff;
            count_in = count_inc;
            sum_in   = sum_add;
            if (count_inc >= len_ff) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            res.event_kind = (sum_ff == byte_ff) ? EV_GOOD : EV_BAD;
            phase_in = PH_HUNT;
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
      res.frame_id     = id_in;
      res.frame_length = len_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= PH_HUNT;
         sum_ff   <= '0;
         id_ff    <= '0;
         len_ff   <= '0;
         count_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         // Commit state only when the beat leaves for the output stage
         if (advance) begin
            phase_ff <= phase_in;
            sum_ff   <= sum_in;
            id_ff    <= id_in;
            len_ff   <= len_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

endmodule
`default_nettype wire

/* src/cfr_out_reg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cfr_out_reg
// Result register: holds one finished beat until the receiver takes it.
// ----------------------------------------------------------------------------
module cfr_out_reg
   import cfr_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic res_valid,
   output logic      res_ready,
   input  wire result_type res,
   output logic      out_valid,
   input  wire logic out_ready,
   output result_type out_res
);

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // Load whenever the register is empty or being drained this cycle
   assign res_ready = !valid_ff || out_ready;
   assign valid_in  = res_ready ? res_valid : valid_ff;
   assign data_in   = (res_ready && res_valid) ? res : data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_res   = data_ff;

endmodule
`default_nettype wire

/* tb/frame_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_checker
// Watches the request, result and control channels of the frame receiver,
// predicts one result per accepted request beat from a local copy of the
// deframing state and compares every result beat, field by field, in order.
// ----------------------------------------------------------------------------
module frame_checker
   import cfr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [BYTE_W-1:0]      req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [KIND_W-1:0]      rsp_tuser,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int unsigned            outstanding,
   output int unsigned            mismatches
);

   // Local copy of the registers and of the framing state
   logic [BYTE_W-1:0]     header_cfg;
   logic [ID_LIMIT_W-1:0] limit_cfg;
   phase_type             parse_phase;
   logic [BYTE_W-1:0]     frame_sum;
   logic [BYTE_W-1:0]     held_id;
   logic [BYTE_W-1:0]     held_len;
   logic [BYTE_W-1:0]     data_count;

   result_type expected_results[$];

   // Advance the framing state by one received byte and build its result
   function automatic result_type deframe_byte(input logic [BYTE_W-1:0] rx);
      result_type r;
      r = '0;
      r.event_kind = EV_NONE;
      case (parse_phase)
         PH_HUNT: begin
            if (rx == header_cfg) begin
               frame_sum   = rx;
               held_id     = '0;
               held_len    = '0;
               data_count  = '0;
               parse_phase = PH_ID;
            end
         end
         PH_ID: begin
            if ({1'b0, rx} < limit_cfg) begin
               held_id     = rx;
               frame_sum   = frame_sum + rx;
               parse_phase = PH_LEN;
            end else begin
               parse_phase = PH_HUNT;
            end
         end
         PH_LEN: begin
            held_len    = rx;
            frame_sum   = frame_sum + rx;
            parse_phase = (rx == '0) ? PH_CHECK : PH_DATA;
         end
         PH_DATA: begin
            r.event_kind    = EV_DATA;
            r.payload_byte  = rx;
            r.payload_index = data_count;
            data_count      = data_count + 1'b1;
            frame_sum       = frame_sum + rx;
            if (data_count >= held_len)
               parse_phase = PH_CHECK;
         end
         PH_CHECK: begin
            r.event_kind = (frame_sum == rx) ? EV_GOOD : EV_BAD;
            parse_phase  = PH_HUNT;
         end
         default: begin
            parse_phase = PH_HUNT;
         end
      endcase
      r.frame_id     = held_id;
      r.frame_length = held_len;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [BYTE_W-1:0] want,
                                       input logic [BYTE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         header_cfg  = HEADER_BYTE_RESET;
         limit_cfg   = ID_LIMIT_RESET;
         parse_phase = PH_HUNT;
         frame_sum   = '0;
         held_id     = '0;
         held_len    = '0;
         data_count  = '0;
         expected_results.delete();
         outstanding = 0;
      end else begin
         // Track register writes; spare indexes change nothing
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_HEADER_BYTE: header_cfg = csr_data[BYTE_W-1:0];
               CSR_ID_LIMIT:    limit_cfg  = csr_data[ID_LIMIT_W-1:0];
               default: ;
            endcase
         end

         // Compare a result beat with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result beat with no prediction waiting: tuser %0d tdata %h",
                      rsp_tuser, rsp_tdata);
               mismatches++;
            end else begin
               result_type want;
               want = expected_results.pop_front();
               check_field("event_kind", BYTE_W'(want.event_kind), BYTE_W'(rsp_tuser));
               check_field("payload_byte", want.payload_byte, rsp_tdata[7:0]);
               check_field("payload_index", want.payload_index, rsp_tdata[15:8]);
               check_field("frame_id", want.frame_id, rsp_tdata[23:16]);
               check_field("frame_length", want.frame_length, rsp_tdata[31:24]);
            end
         end

         // Predict the result of each accepted byte
         if (req_tvalid && req_tready)
            expected_results.push_back(deframe_byte(req_tdata));

         outstanding = expected_results.size();
      end
   end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the frame receiver with byte streams: a short directed set of
// frames, then phases of random frames, noise and broken frames under
// several header and id limit settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
   import cfr_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_3 = 2'd3;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [BYTE_W-1:0]      req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [KIND_W-1:0]      rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   int unsigned outstanding;
   int unsigned mismatches;
   int unsigned cycle_count = 0;
   int unsigned frame_bytes = 0;
   bit          calm = 1'b0;

   logic [BYTE_W-1:0]     header_now = HEADER_BYTE_RESET;
   logic [ID_LIMIT_W-1:0] limit_now  = ID_LIMIT_RESET;

   always #5 clock = ~clock;

   checksummed_frame_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   frame_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("checksummed_frame_receiver verification failed");
         $finish;
      end
   end

   // Result side: ready stretches broken by stall bursts, none when calm
   initial begin
      forever begin
         rsp_tready <= 1'b1;
         if (calm) begin
            @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 40)) @(posedge clock);
            if (!calm) begin
               rsp_tready <= 1'b0;
               repeat ($urandom_range(1, 14)) @(posedge clock);
            end
         end
      end
   end

   // Offer one byte, after an optional idle burst, and hold it until taken
   task automatic send_byte(input logic [BYTE_W-1:0] value);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   // Header, id, length, payload and sum; optionally spoil the sum
   task automatic send_frame(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] id,
                             input logic [BYTE_W-1:0] len, input bit corrupt);
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] b;
      sum = hdr + id + len;
      send_byte(hdr);
      send_byte(id);
      send_byte(len);
      for (int i = 0; i < len; i++) begin
         b = BYTE_W'($urandom);
         sum = sum + b;
         send_byte(b);
      end
      if (corrupt)
         sum = sum ^ BYTE_W'($urandom_range(1, 255));
      send_byte(sum);
      frame_bytes += len + 4;
   endtask

   // Hold off the sender until every predicted result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] hdr,
                             input logic [CSR_DATA_W-1:0] lim);
      drain_results();
      write_reg(CSR_HEADER_BYTE, hdr);
      write_reg(CSR_ID_LIMIT, lim);
      header_now = hdr[BYTE_W-1:0];
      limit_now  = lim[ID_LIMIT_W-1:0];
   endtask

   // One random sequence: mostly well-formed frames, some noise and damage
   task automatic send_random_traffic();
      int unsigned pick;
      int unsigned id_top;
      int unsigned cut;
      logic [BYTE_W-1:0] id;
      logic [BYTE_W-1:0] len;
      pick   = $urandom_range(0, 99);
      id_top = (limit_now > 256) ? 256 : limit_now;
      if (id_top == 0)
         id = BYTE_W'($urandom);
      else
         id = BYTE_W'($urandom_range(0, id_top - 1));
      len = ($urandom_range(0, 79) == 0) ? 8'd255 : BYTE_W'($urandom_range(0, 12));
      if (pick < 75) begin
         send_frame(header_now, id, len, $urandom_range(0, 6) == 0);
      end else if (pick < 85) begin
         repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom));
      end else if (pick < 93) begin
         // Id at or above the limit where the limit leaves room
         if (limit_now <= 255)
            id = BYTE_W'($urandom_range(limit_now, 255));
         send_frame(header_now, id, BYTE_W'($urandom_range(0, 4)), 1'b0);
      end else begin
         // Cut a frame short; following bytes land in its payload
         len = BYTE_W'($urandom_range(2, 12));
         cut = $urandom_range(1, len - 1);
         send_byte(header_now);
         send_byte(id);
         send_byte(len);
         repeat (cut) send_byte(BYTE_W'($urandom));
         frame_bytes += cut + 3;
      end
      if ($urandom_range(0, 39) == 0)
         drain_results();
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] hdr,
                            input logic [CSR_DATA_W-1:0] lim, input int unsigned budget);
      int unsigned target;
      set_config(hdr, lim);
      target = frame_bytes + budget;
      while (frame_bytes < target)
         send_random_traffic();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed: reset defaults, noise while hunting, zero length, extremes
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(8'd90, 8'd0, 8'd0, 1'b0);
      send_frame(8'd90, 8'd7, 8'd2, 1'b0);
      send_frame(8'd90, 8'd3, 8'd1, 1'b1);
      send_frame(8'd90, 8'd8, 8'd0, 1'b0);
      // No id passes a limit of zero; every id passes a limit of 256
      set_config(9'h0FF, 9'd0);
      send_frame(8'hFF, 8'd0, 8'd0, 1'b0);
      set_config(9'h0FF, 9'd256);
      send_frame(8'hFF, 8'd255, 8'd1, 1'b0);

      // Random phases over several register settings
      run_phase(9'd90, 9'd8, 350);
      run_phase(9'd0, 9'd1, 300);
      run_phase(9'h1FF, 9'd256, 350);
      run_phase(CSR_DATA_W'($urandom_range(0, 511)), CSR_DATA_W'($urandom_range(1, 511)),
                350);
      drain_results();
      write_reg(CSR_SPARE_2, CSR_DATA_W'($urandom));
      write_reg(CSR_SPARE_3, CSR_DATA_W'($urandom));
      run_phase(9'h1A5, 9'd0, 150);
      drain_results();
      calm = 1'b1;
      run_phase(CSR_DATA_W'($urandom_range(0, 511)), 9'd511, 350);

      drain_results();
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("checksummed_frame_receiver verification clean");
      else
         $display("checksummed_frame_receiver verification failed");
      $finish;
   end

endmodule
